>>> hdl/cpid2_pkg.sv
//------------------------------------------------------------------------------
// cpid2_pkg
// Shared types and constants of the two-axis cascaded PID controller.
//------------------------------------------------------------------------------
package cpid2_pkg;

  // Width of the divisor and remainder in the serial divider
  localparam int DENW = 20;

  // Operation of the shared multiply/divide unit
  typedef enum logic {
    MDU_MULQ,
    MDU_SCALE
  } mdu_op_e;

  // Phase of the shared multiply/divide unit
  typedef enum logic [2:0] {
    MP_IDLE,
    MP_MUL,
    MP_PREP,
    MP_DIV,
    MP_SAT
  } mdu_phase_e;

  // Request from the sequencer to the multiply/divide unit
  typedef struct packed {
    logic    start;
    mdu_op_e op;
    logic    neg;
  } mdu_req_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OUTER_KP,
    REG_OUTER_KI,
    REG_OUTER_KD,
    REG_INNER_KP,
    REG_INNER_KI,
    REG_INNER_KD,
    REG_FF_BLEND,
    REG_PERIOD
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_O_ERR,
    ST_O_W,
    ST_O_F,
    ST_O_D1,
    ST_O_D2,
    ST_O_D3,
    ST_O_I1,
    ST_O_I2,
    ST_O_SUM,
    ST_O_RES,
    ST_I_DEM,
    ST_I_DAMP,
    ST_I_D1,
    ST_I_D2,
    ST_I_I1,
    ST_I_I2,
    ST_I_LW,
    ST_I_FF1,
    ST_I_FF2,
    ST_I_SUM,
    ST_I_P1,
    ST_I_P2,
    ST_OUT
  } cpid2_state_e;

endpackage

>>> hdl/cpid2_mdu.sv
//------------------------------------------------------------------------------
// cpid2_mdu
// Bit-serial multiply / divide unit. MULQ returns round(a*b / 2^FRAC_BITS),
// SCALE returns round(a*b / den); both round half away from zero and
// saturate the signed result to DATA_WIDTH bits.
//------------------------------------------------------------------------------
module cpid2_mdu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cpid2_pkg::mdu_req_t                   req_i,
  input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] a_i,
  input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] b_i,
  input  logic [cpid2_pkg::DENW-1:0]            den_i,
  output logic                                  done_o,
  output logic signed [DATA_WIDTH-1:0]          res_o
);
  import cpid2_pkg::*;

  localparam int OW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int PW = 2 * OW;
  localparam int SW = DATA_WIDTH + 21;
  localparam int CW = $clog2(SW + 1);
  localparam logic [PW:0]   RndInc = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] MagMax = PW'((longint'(1) << (DATA_WIDTH - 1)) - 1);
  localparam logic [PW-1:0] MagMin = MagMax + PW'(1);

  mdu_phase_e            ph_q, ph_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [OW-1:0]         a_q, a_d, m_q, m_d;
  logic [PW-1:0]         p_q, p_d, mag_q, mag_d;
  logic [DENW-1:0]       den_q, den_d, r_q, r_d;
  logic                  neg_q, neg_d;
  mdu_op_e               op_q, op_d;
  logic [SW-1:0]         n_q, n_d;
  logic signed [DATA_WIDTH-1:0] res_q, res_d;

  logic [OW:0]           sum;
  logic [PW:0]           rnd;
  logic [DENW:0]         rem2;
  logic [PW-1:0]         mv;

  // Step the multiply, divide and saturate phases
  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    m_d    = m_q;
    p_d    = p_q;
    mag_d  = mag_q;
    den_d  = den_q;
    r_d    = r_q;
    neg_d  = neg_q;
    op_d   = op_q;
    n_d    = n_q;
    res_d  = res_q;
    done_d = 1'b0;
    sum    = {1'b0, p_q[PW-1:OW]} + (m_q[0] ? {1'b0, a_q} : '0);
    rnd    = {1'b0, p_q} + RndInc;
    rem2   = {r_q, n_q[SW-1]};
    mv     = (op_q == MDU_SCALE) ? PW'(n_q) : mag_q;
    unique case (ph_q)
      MP_IDLE: begin
        if (req_i.start) begin
          a_d   = a_i;
          m_d   = b_i;
          p_d   = '0;
          den_d = den_i;
          neg_d = req_i.neg;
          op_d  = req_i.op;
          cnt_d = '0;
          ph_d  = MP_MUL;
        end
      end
      MP_MUL: begin
        p_d   = {sum, p_q[OW-1:1]};
        m_d   = m_q >> 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(OW - 1)) begin
          ph_d = MP_PREP;
        end
      end
      MP_PREP: begin
        if (op_q == MDU_MULQ) begin
          mag_d = PW'(rnd >> FRAC_BITS);
          ph_d  = MP_SAT;
        end else begin
          n_d   = SW'(p_q) + SW'(den_q >> 1);
          r_d   = '0;
          cnt_d = '0;
          ph_d  = MP_DIV;
        end
      end
      MP_DIV: begin
        // One restoring division step per cycle
        if (rem2 >= {1'b0, den_q}) begin
          r_d = DENW'(rem2 - {1'b0, den_q});
          n_d = {n_q[SW-2:0], 1'b1};
        end else begin
          r_d = rem2[DENW-1:0];
          n_d = {n_q[SW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(SW - 1)) begin
          ph_d = MP_SAT;
        end
      end
      MP_SAT: begin
        if (neg_q) begin
          res_d = (mv > MagMin) ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : -mv[DATA_WIDTH-1:0];
        end else begin
          res_d = (mv > MagMax) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : mv[DATA_WIDTH-1:0];
        end
        done_d = 1'b1;
        ph_d   = MP_IDLE;
      end
      default: ph_d = MP_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= MP_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    m_q   <= m_d;
    p_q   <= p_d;
    mag_q <= mag_d;
    den_q <= den_d;
    r_q   <= r_d;
    neg_q <= neg_d;
    op_q  <= op_d;
    n_q   <= n_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/cascaded_pid_two_axis_unit.sv
//------------------------------------------------------------------------------
// cascaded_pid_two_axis_unit
// Two-axis cascaded PID controller in signed fixed point, one loop per item.
//------------------------------------------------------------------------------
// An item with tuser 0 runs the outer position loop on both axes, an item with
// tuser 1 runs the inner rate loop; one result transfer follows each item.
// All products and scalings go through a single bit-serial multiply/divide
// unit. The outer loop does 5 MULQ and 3 scalings per axis, the inner loop
// 7 MULQ and 3 scalings per axis.
// The input side takes a new item as soon as the sequencer is idle, even while
// the previous result still waits in the output register.
module cascaded_pid_two_axis_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: target_x, target_y, pos_x, pos_y, gyro_x, gyro_y (32 bits each)
  input  logic [191:0] s_axis_tdata,
  // tuser: cmd
  input  logic         s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: drive_x, drive_y (32 bits each)
  output logic [63:0]  m_axis_tdata,
  // tuser: loop_id
  output logic         m_axis_tuser,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import cpid2_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int XW = DATA_WIDTH + 10;
  localparam int OW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  localparam longint One   = longint'(1) << FRAC_BITS;
  localparam longint DwMax = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint Qc65  = (65 * One * 2 + 100) / 200;
  localparam longint Qc35  = (35 * One * 2 + 100) / 200;
  localparam longint Qc45  = (45 * One * 2 + 100) / 200;
  localparam longint Qc55  = (55 * One * 2 + 100) / 200;

  localparam logic signed [XW-1:0] OneX   = XW'(One);
  localparam logic signed [XW-1:0] DwMaxX = XW'(DwMax);
  localparam logic signed [XW-1:0] DwMinX = -DwMaxX - XW'(1);
  localparam logic signed [XW-1:0] Lim8X  = XW'(8 * One);
  localparam logic signed [XW-1:0] Lim10X = XW'(10 * One);
  localparam logic signed [XW-1:0] Lim30X = XW'(30 * One);
  localparam logic signed [XW-1:0] Lim60X = XW'(60 * One);
  localparam logic signed [XW-1:0] Qc65X  = XW'(Qc65);
  localparam logic signed [XW-1:0] Qc45X  = XW'(Qc45);
  localparam logic signed [XW-1:0] Max32X = XW'(longint'(32'h7FFF_FFFF));
  localparam logic signed [XW-1:0] Min32X = -Max32X - XW'(1);
  localparam logic [OW-1:0]        Qc35W  = OW'(Qc35);
  localparam logic [OW-1:0]        Qc55W  = OW'(Qc55);
  localparam logic [OW-1:0]        Num1   = OW'(1);
  localparam logic [OW-1:0]        Num2k  = OW'(2000);
  localparam logic [OW-1:0]        Num5k  = OW'(5000);
  localparam logic [DENW-1:0]      Den5   = DENW'(5);
  localparam logic [DENW-1:0]      DenMeg = DENW'(1000000);

  // Saturate a wide value to DATA_WIDTH bits
  function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > DwMaxX) begin
      r = DwMaxX[DW-1:0];
    end else if (v < DwMinX) begin
      r = DwMinX[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] ext(input logic signed [DW-1:0] v);
    return XW'(v);
  endfunction

  function automatic logic signed [XW-1:0] clamp_x(input logic signed [XW-1:0] v,
                                                   input logic signed [XW-1:0] lo,
                                                   input logic signed [XW-1:0] hi);
    logic signed [XW-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] mag_x(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] a;
    a = v[XW-1] ? -v : v;
    return a[OW-1:0];
  endfunction

  function automatic logic [31:0] out32(input logic signed [DW-1:0] v);
    logic signed [XW-1:0] c;
    c = clamp_x(ext(v), Min32X, Max32X);
    return c[31:0];
  endfunction

  // Configuration registers
  logic [63:0] okp_q, oki_q, okd_q, ikp_q, iki_q, ikd_q;
  logic [16:0] fb_q;
  logic [15:0] per_q;

  // Sequencer and per-axis state
  cpid2_state_e state_q, state_d;
  logic         ax_q, ax_d, run_q, run_d;
  logic         cmd_q, cmd_d;
  logic [191:0] in_q, in_d;
  logic signed [DW-1:0] err_q, err_d, w_q, w_d, d_q, d_d, ig_q, ig_d;
  logic signed [DW-1:0] s_q, s_d, t_q, t_d, dem_q, dem_d, g_q, g_d;
  logic signed [XW-1:0] f_q, f_d;
  logic signed [DW-1:0] oint_q [2], oint_d [2], perr_q [2], perr_d [2];
  logic signed [DW-1:0] ores_q [2], ores_d [2], owgt_q [2], owgt_d [2];
  logic signed [DW-1:0] iint_q [2], iint_d [2], pgyr_q [2], pgyr_d [2];
  logic [31:0]  drv_q [2], drv_d [2];
  logic         out_valid_q, out_valid_d, out_user_q, out_user_d;
  logic [63:0]  out_data_q, out_data_d;

  // Multiply/divide unit handshake
  mdu_req_t             req;
  logic [OW-1:0]        mdu_a, mdu_b;
  logic [DENW-1:0]      mdu_den;
  logic                 mdu_done, use_mdu, fin;
  logic signed [DW-1:0] mdu_res;

  // Axis operands
  logic [31:0]          kp_o, ki_o, kd_o, kp_i, ki_i, kd_i;
  logic [DENW-1:0]      per;
  logic signed [XW-1:0] fbx, rx, tmp_x, ec_x, dem_x;
  logic signed [DW-1:0] de, damp_in, g_in, tmp_dw;
  logic                 in_acc, cfg_wr;

  assign kp_o    = ax_q ? okp_q[63:32] : okp_q[31:0];
  assign ki_o    = ax_q ? oki_q[63:32] : oki_q[31:0];
  assign kd_o    = ax_q ? okd_q[63:32] : okd_q[31:0];
  assign kp_i    = ax_q ? ikp_q[63:32] : ikp_q[31:0];
  assign ki_i    = ax_q ? iki_q[63:32] : iki_q[31:0];
  assign kd_i    = ax_q ? ikd_q[63:32] : ikd_q[31:0];
  assign per     = (per_q == 16'd0) ? DENW'(1) : DENW'(per_q);
  assign fbx     = clamp_x(XW'(fb_q), '0, OneX);
  assign rx      = ext(mdu_res);
  assign ec_x    = clamp_x(ext(err_q), -Lim10X, Lim10X);
  assign de      = sat_x(ext(err_q) - ext(perr_q[ax_q]));
  assign damp_in = sat_x(ext(g_q) - ext(pgyr_q[ax_q]));
  assign g_in    = sat_x(XW'(signed'(ax_q ? in_q[191:160] : in_q[159:128])));
  assign dem_x   = clamp_x(ext(sat_x(ext(ores_q[ax_q]) <<< 1)), -Lim60X, Lim60X);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // Sequence the loop steps for each axis
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    cmd_d       = cmd_q;
    in_d        = in_q;
    err_d       = err_q;
    w_d         = w_q;
    d_d         = d_q;
    ig_d        = ig_q;
    s_d         = s_q;
    t_d         = t_q;
    dem_d       = dem_q;
    g_d         = g_q;
    f_d         = f_q;
    oint_d      = oint_q;
    perr_d      = perr_q;
    ores_d      = ores_q;
    owgt_d      = owgt_q;
    iint_d      = iint_q;
    pgyr_d      = pgyr_q;
    drv_d       = drv_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_user_d  = out_user_q;
    out_data_d  = out_data_q;
    use_mdu     = 1'b0;
    req.op      = MDU_MULQ;
    req.neg     = 1'b0;
    mdu_a       = '0;
    mdu_b       = '0;
    mdu_den     = Den5;
    tmp_x       = '0;
    tmp_dw      = '0;
    fin         = run_q && mdu_done;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = s_axis_tuser;
          in_d    = s_axis_tdata;
          ax_d    = 1'b0;
          state_d = s_axis_tuser ? ST_I_DEM : ST_O_ERR;
        end
      end
      // Outer position loop
      ST_O_ERR: begin
        err_d   = sat_x(ext(sat_x(XW'(signed'(ax_q ? in_q[63:32] : in_q[31:0]))))
                      - ext(sat_x(XW'(signed'(ax_q ? in_q[127:96] : in_q[95:64])))));
        state_d = ST_O_W;
      end
      ST_O_W: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(err_q));
        mdu_b   = Num1;
        mdu_den = Den5;
        if (fin) begin
          w_d     = mdu_res;
          state_d = ST_O_F;
        end
      end
      ST_O_F: begin
        use_mdu = 1'b1;
        mdu_a   = Qc35W;
        mdu_b   = mag_x(ext(w_q));
        if (fin) begin
          f_d     = ext(sat_x(Qc65X + rx));
          state_d = ST_O_D1;
        end
      end
      ST_O_D1: begin
        use_mdu = 1'b1;
        mdu_a   = OW'(kd_o);
        mdu_b   = mag_x(ext(de));
        req.neg = de[DW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_O_D2;
        end
      end
      ST_O_D2: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(d_q));
        mdu_b   = Num5k;
        mdu_den = per;
        req.neg = d_q[DW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_O_D3;
        end
      end
      ST_O_D3: begin
        use_mdu = 1'b1;
        mdu_a   = mag_x(ext(d_q));
        mdu_b   = mag_x(f_q);
        req.neg = d_q[DW-1] ^ f_q[XW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_O_I1;
        end
      end
      ST_O_I1: begin
        use_mdu = 1'b1;
        mdu_a   = OW'(ki_o);
        mdu_b   = mag_x(ext(err_q));
        req.neg = err_q[DW-1];
        if (fin) begin
          ig_d    = mdu_res;
          state_d = ST_O_I2;
        end
      end
      ST_O_I2: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(ig_q));
        mdu_b   = OW'(per);
        mdu_den = DenMeg;
        req.neg = ig_q[DW-1];
        if (fin) begin
          tmp_dw = sat_x(ext(oint_q[ax_q]) + rx);
          // Drop the integrator once it leaves its window
          if (ext(tmp_dw) > Lim8X || ext(tmp_dw) < -Lim8X) begin
            ig_d = '0;
          end else begin
            ig_d = tmp_dw;
          end
          state_d = ST_O_SUM;
        end
      end
      ST_O_SUM: begin
        s_d     = sat_x(ec_x + ext(d_q) + ext(ig_q));
        state_d = ST_O_RES;
      end
      ST_O_RES: begin
        use_mdu = 1'b1;
        mdu_a   = OW'(kp_o);
        mdu_b   = mag_x(ext(s_q));
        req.neg = s_q[DW-1];
        if (fin) begin
          ores_d[ax_q] = mdu_res;
          oint_d[ax_q] = ig_q;
          perr_d[ax_q] = ec_x[DW-1:0];
          owgt_d[ax_q] = w_q;
          drv_d[ax_q]  = out32(mdu_res);
          ax_d         = 1'b1;
          state_d      = ax_q ? ST_OUT : ST_O_ERR;
        end
      end
      // Inner rate loop
      ST_I_DEM: begin
        g_d     = g_in;
        dem_d   = dem_x[DW-1:0];
        err_d   = sat_x(dem_x + ext(g_in));
        state_d = ST_I_DAMP;
      end
      ST_I_DAMP: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(damp_in));
        mdu_b   = Num2k;
        mdu_den = per;
        req.neg = damp_in[DW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_I_D1;
        end
      end
      ST_I_D1: begin
        // Negate the damping term through the sign
        use_mdu = 1'b1;
        mdu_a   = OW'(kd_i);
        mdu_b   = mag_x(ext(d_q));
        req.neg = !d_q[DW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_I_D2;
        end
      end
      ST_I_D2: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(d_q));
        mdu_b   = Num2k;
        mdu_den = per;
        req.neg = d_q[DW-1];
        if (fin) begin
          d_d     = mdu_res;
          state_d = ST_I_I1;
        end
      end
      ST_I_I1: begin
        use_mdu = 1'b1;
        mdu_a   = OW'(ki_i);
        mdu_b   = mag_x(ext(err_q));
        req.neg = err_q[DW-1];
        if (fin) begin
          ig_d    = mdu_res;
          state_d = ST_I_I2;
        end
      end
      ST_I_I2: begin
        use_mdu = 1'b1;
        req.op  = MDU_SCALE;
        mdu_a   = mag_x(ext(ig_q));
        mdu_b   = OW'(per);
        mdu_den = DenMeg;
        req.neg = ig_q[DW-1];
        if (fin) begin
          tmp_x   = clamp_x(ext(sat_x(ext(iint_q[ax_q]) + rx)), -Lim30X, Lim30X);
          ig_d    = tmp_x[DW-1:0];
          state_d = ST_I_LW;
        end
      end
      ST_I_LW: begin
        use_mdu = 1'b1;
        mdu_a   = Qc55W;
        mdu_b   = mag_x(ext(owgt_q[ax_q]));
        req.neg = owgt_q[ax_q][DW-1];
        if (fin) begin
          f_d     = clamp_x(Qc45X + rx, '0, OneX);
          state_d = ST_I_FF1;
        end
      end
      ST_I_FF1: begin
        use_mdu = 1'b1;
        mdu_a   = mag_x(fbx);
        mdu_b   = mag_x(f_q);
        if (fin) begin
          f_d     = rx;
          state_d = ST_I_FF2;
        end
      end
      ST_I_FF2: begin
        use_mdu = 1'b1;
        mdu_a   = mag_x(f_q);
        mdu_b   = mag_x(ext(dem_q));
        req.neg = f_q[XW-1] ^ dem_q[DW-1];
        if (fin) begin
          f_d     = rx;
          state_d = ST_I_SUM;
        end
      end
      ST_I_SUM: begin
        s_d     = sat_x(ext(err_q) + ext(d_q) + ext(ig_q));
        state_d = ST_I_P1;
      end
      ST_I_P1: begin
        use_mdu = 1'b1;
        mdu_a   = mag_x(OneX - fbx);
        mdu_b   = OW'(kp_i);
        if (fin) begin
          t_d     = mdu_res;
          state_d = ST_I_P2;
        end
      end
      ST_I_P2: begin
        use_mdu = 1'b1;
        mdu_a   = mag_x(ext(t_q));
        mdu_b   = mag_x(ext(s_q));
        req.neg = t_q[DW-1] ^ s_q[DW-1];
        if (fin) begin
          tmp_dw       = sat_x(f_q + rx);
          iint_d[ax_q] = ig_q;
          pgyr_d[ax_q] = g_q;
          drv_d[ax_q]  = out32(tmp_dw);
          ax_d         = 1'b1;
          state_d      = ax_q ? ST_OUT : ST_I_DEM;
        end
      end
      // Hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = cmd_q;
          out_data_d  = {drv_q[1], drv_q[0]};
          ax_d        = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    req.start = use_mdu && !run_q;
    run_d     = use_mdu ? (run_q ? !mdu_done : 1'b1) : run_q;
  end

  cpid2_mdu #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mdu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .a_i   (mdu_a),
    .b_i   (mdu_b),
    .den_i (mdu_den),
    .done_o(mdu_done),
    .res_o (mdu_res)
  );

  // Control and loop state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      oint_q      <= '{default: '0};
      perr_q      <= '{default: '0};
      ores_q      <= '{default: '0};
      owgt_q      <= '{default: '0};
      iint_q      <= '{default: '0};
      pgyr_q      <= '{default: '0};
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      oint_q      <= oint_d;
      perr_q      <= perr_d;
      ores_q      <= ores_d;
      owgt_q      <= owgt_d;
      iint_q      <= iint_d;
      pgyr_q      <= pgyr_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    in_q       <= in_d;
    err_q      <= err_d;
    w_q        <= w_d;
    d_q        <= d_d;
    ig_q       <= ig_d;
    s_q        <= s_d;
    t_q        <= t_d;
    dem_q      <= dem_d;
    g_q        <= g_d;
    f_q        <= f_d;
    drv_q      <= drv_d;
    out_user_q <= out_user_d;
    out_data_q <= out_data_d;
  end

  // Configuration writes
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      okp_q <= '0;
      oki_q <= '0;
      okd_q <= '0;
      ikp_q <= '0;
      iki_q <= '0;
      ikd_q <= '0;
      fb_q  <= '0;
      per_q <= 16'd2000;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[5:3]))
        REG_OUTER_KP: okp_q <= pwdata;
        REG_OUTER_KI: oki_q <= pwdata;
        REG_OUTER_KD: okd_q <= pwdata;
        REG_INNER_KP: ikp_q <= pwdata;
        REG_INNER_KI: iki_q <= pwdata;
        REG_INNER_KD: ikd_q <= pwdata;
        REG_FF_BLEND: fb_q  <= pwdata[16:0];
        REG_PERIOD:   per_q <= pwdata[15:0];
        default:      per_q <= per_q;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (cfg_reg_e'(paddr[5:3]))
      REG_OUTER_KP: prdata = okp_q;
      REG_OUTER_KI: prdata = oki_q;
      REG_OUTER_KD: prdata = okd_q;
      REG_INNER_KP: prdata = ikp_q;
      REG_INNER_KI: prdata = iki_q;
      REG_INNER_KD: prdata = ikd_q;
      REG_FF_BLEND: prdata = {47'd0, fb_q};
      REG_PERIOD:   prdata = {48'd0, per_q};
      default:      prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> hdl/cpid2_chk.sv
//------------------------------------------------------------------------------
// cpid2_chk
// Port-level checks of the two-axis cascaded PID controller.
//------------------------------------------------------------------------------
module cpid2_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Count items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while a loop update runs");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without a pending item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

endmodule

bind cascaded_pid_two_axis_unit cpid2_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
